// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion that is switched off while reset is low
`define ASSERT_CLKD(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that is also checked through reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/y2a_pkg.sv =====
// types and constants for the yuy2 to argb converter
`default_nettype none

package y2a_pkg;

  // input beat: one yuy2 macropixel
  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] chroma_blue;
    logic [7:0] luma_second;
    logic [7:0] chroma_red;
    logic       frame_end_in;
  } y2a_in_t;

  // result beat: two argb pixels
  typedef struct packed {
    logic [31:0] argb_first;
    logic [31:0] argb_second;
    logic        frame_end_out;
  } y2a_out_t;

  // colour coefficients, 20 fractional bits
  localparam logic signed [22:0] COEF_RV = 23'sd1370705;
  localparam logic signed [22:0] COEF_GU = 23'sd337233;
  localparam logic signed [22:0] COEF_GV = 23'sd698200;
  localparam logic signed [22:0] COEF_BU = 23'sd1732480;

  // flipping the top bit of an offset-binary byte gives value minus 128
  localparam logic [7:0] CHROMA_BIAS = 8'h80;
  localparam int unsigned FRAC_BITS = 20;
  localparam logic [7:0] ALPHA_BYTE = 8'hFF;
  localparam logic [7:0] CHAN_MAX = 8'hFF;

  // product width and width of a chroma term after the shift
  localparam int unsigned PROD_W = 31;
  localparam int unsigned DELTA_W = 10;
  localparam int unsigned CHAN_W = 11;

endpackage

`default_nettype wire

// ===== rtl/yuy2_to_argb_converter.sv =====
// yuy2 macropixel to two argb pixels, two register stages: input beat, then result beat
// throughput: one macropixel per cycle while out_stall is low; the input and
// result registers form a two-deep pipeline, a stage holds its beat while the
// stage after it is full and stalled
// reset: rst_n low clears the valid bit of each stage, payloads are not reset
`default_nettype none

module yuy2_to_argb_converter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire y2a_pkg::y2a_in_t   in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output y2a_pkg::y2a_out_t       out_data
);
  import y2a_pkg::*;

  // stage valids and load enables
  logic     s0_valid_r, s0_valid_nxt;
  logic     s1_valid_r, s1_valid_nxt;
  logic     s0_load, s1_load;

  // stage payloads
  y2a_in_t  s0_data_r;
  y2a_out_t out_r, out_nxt;

  // pipeline control: a stage loads when it is empty or moving on
  always_comb begin
    s1_load = !s1_valid_r || !out_stall;
    s0_load = !s0_valid_r || s1_load;
    s0_valid_nxt = s0_load ? in_valid : s0_valid_r;
    s1_valid_nxt = s1_load ? s0_valid_r : s1_valid_r;
  end

  assign in_stall  = !s0_load;
  assign out_valid = s1_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= s0_valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // chroma products
  logic signed [7:0] u_s, v_s;
  logic signed [PROD_W-1:0] u_ext, v_ext, prod_gu, prod_gv;
  logic signed [PROD_W-1:0] prod_red, prod_green, prod_blue;

  always_comb begin
    u_s = $signed(s0_data_r.chroma_blue ^ CHROMA_BIAS);
    v_s = $signed(s0_data_r.chroma_red ^ CHROMA_BIAS);
    u_ext = PROD_W'(u_s);
    v_ext = PROD_W'(v_s);
    prod_gu = u_ext * PROD_W'(COEF_GU);
    prod_gv = v_ext * PROD_W'(COEF_GV);
    prod_red = v_ext * PROD_W'(COEF_RV);
    prod_green = prod_gu + prod_gv;
    prod_blue = u_ext * PROD_W'(COEF_BU);
  end

  // input beat register
  always_ff @(posedge clk) begin
    if (s0_load && in_valid) begin
      s0_data_r <= in_data;
    end
  end

  // clamp a channel to one byte
  function automatic logic [7:0] sat8(input logic signed [CHAN_W-1:0] x);
    logic [7:0] res;
    priority if (x < 0) begin
      res = 8'h00;
    end else if (x > $signed(CHAN_W'(CHAN_MAX))) begin
      res = CHAN_MAX;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  // pack one pixel from its luma and the shared chroma terms
  function automatic logic [31:0] pack_pixel(
    input logic [7:0] y,
    input logic signed [DELTA_W-1:0] dr,
    input logic signed [DELTA_W-1:0] dg,
    input logic signed [DELTA_W-1:0] db
  );
    logic signed [CHAN_W-1:0] y_s, r, g, b;
    y_s = $signed({{(CHAN_W-8){1'b0}}, y});
    r = y_s + CHAN_W'(dr);
    g = y_s - CHAN_W'(dg);
    b = y_s + CHAN_W'(db);
    return {ALPHA_BYTE, sat8(r), sat8(g), sat8(b)};
  endfunction

  // arithmetic shift floors the products, then add, clamp and pack
  logic signed [PROD_W-1:0] shr_red, shr_green, shr_blue;
  logic signed [DELTA_W-1:0] dr, dg, db;

  always_comb begin
    shr_red   = prod_red >>> FRAC_BITS;
    shr_green = prod_green >>> FRAC_BITS;
    shr_blue  = prod_blue >>> FRAC_BITS;
    dr = shr_red[DELTA_W-1:0];
    dg = shr_green[DELTA_W-1:0];
    db = shr_blue[DELTA_W-1:0];
    out_nxt.argb_first    = pack_pixel(s0_data_r.luma_first, dr, dg, db);
    out_nxt.argb_second   = pack_pixel(s0_data_r.luma_second, dr, dg, db);
    out_nxt.frame_end_out = s0_data_r.frame_end_in;
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (s1_load && s0_valid_r) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/y2a_checker.sv =====
// port checker for the yuy2 to argb converter and its bind
`default_nettype none
`include "assert_macros.svh"

module y2a_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire y2a_pkg::y2a_in_t  in_data,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire y2a_pkg::y2a_out_t out_data
);
  import y2a_pkg::*;

  // a stalled result beat stays offered
  `ASSERT_CLKD(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "result beat dropped while stalled")

  // a stalled result beat keeps its payload
  `ASSERT_CLKD(a_out_stable, clk, rst_n, out_valid && out_stall |=> $stable(out_data), "result beat changed while stalled")

  // both pixels carry an opaque alpha byte
  `ASSERT_CLKD(a_alpha, clk, rst_n, out_valid |-> (out_data.argb_first[31:24] == ALPHA_BYTE && out_data.argb_second[31:24] == ALPHA_BYTE), "alpha byte not opaque")

  // reset empties the pipeline
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result beat offered after reset")

endmodule

bind yuy2_to_argb_converter y2a_checker u_y2a_checker (.*);

`default_nettype wire

// ===== bench/tb_yuy2_to_argb_converter.sv =====
// self-checking bench for the yuy2 to argb converter: directed and random macropixels
module tb_yuy2_to_argb_converter;
  import y2a_pkg::*;

  // expected pixel pairs, worked out from each accepted macropixel
  class argb_scoreboard;
    y2a_out_t pixels_due[$];
    int       fails;

    function new();
      fails = 0;
    endfunction

    // saturate a colour channel to one byte
    function logic [7:0] clamp_chan(longint x);
      if (x < 0) return 8'h00;
      if (x > 255) return CHAN_MAX;
      return x[7:0];
    endfunction

    // colour conversion, arithmetic shift floors the negative terms
    function y2a_out_t convert_macropixel(y2a_in_t mp);
      longint   u, v, dr, dg, db, y1, y2;
      y2a_out_t px;
      u  = longint'(int'(mp.chroma_blue) - int'(CHROMA_BIAS));
      v  = longint'(int'(mp.chroma_red) - int'(CHROMA_BIAS));
      y1 = longint'(int'(mp.luma_first));
      y2 = longint'(int'(mp.luma_second));
      dr = (longint'(COEF_RV) * v) >>> FRAC_BITS;
      dg = (longint'(COEF_GU) * u + longint'(COEF_GV) * v) >>> FRAC_BITS;
      db = (longint'(COEF_BU) * u) >>> FRAC_BITS;
      px.argb_first  = {ALPHA_BYTE, clamp_chan(y1 + dr), clamp_chan(y1 - dg),
                        clamp_chan(y1 + db)};
      px.argb_second = {ALPHA_BYTE, clamp_chan(y2 + dr), clamp_chan(y2 - dg),
                        clamp_chan(y2 + db)};
      px.frame_end_out = mp.frame_end_in;
      return px;
    endfunction

    function void note_macropixel(y2a_in_t mp);
      pixels_due.push_back(convert_macropixel(mp));
    endfunction

    // compare a result beat with the oldest expected pair
    function void check_pixels(y2a_out_t got);
      y2a_out_t want;
      if (pixels_due.size() == 0) begin
        $error("unexpected result beat: %h", got);
        fails++;
        return;
      end
      want = pixels_due.pop_front();
      if (got.argb_first !== want.argb_first) begin
        $error("argb_first expected %h actual %h", want.argb_first, got.argb_first);
        fails++;
      end
      if (got.argb_second !== want.argb_second) begin
        $error("argb_second expected %h actual %h", want.argb_second, got.argb_second);
        fails++;
      end
      if (got.frame_end_out !== want.frame_end_out) begin
        $error("frame_end_out expected %b actual %b", want.frame_end_out,
               got.frame_end_out);
        fails++;
      end
    endfunction

    function int pending();
      return pixels_due.size();
    endfunction
  endclass

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_BEATS = 1650;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  y2a_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  y2a_out_t out_data;

  argb_scoreboard sb = new();
  bit idle_on;
  int quiet_cycles;

  yuy2_to_argb_converter u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock, period 2
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver stalls at random unless the quiet stretch is running
  always @(posedge clk) begin
    out_stall <= idle_on && ($urandom_range(99) < 31);
  end

  // beat monitor and watchdog on cycles with no traffic
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_macropixel(in_data);
      if (out_valid && !out_stall) sb.check_pixels(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // random byte leaning towards the extremes and the chroma midpoint
  function logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 8'h00;
    if (r < 8) return 8'hFF;
    if (r < 12) return $urandom_range(1) ? 8'h7F : 8'h80;
    return 8'($urandom_range(255));
  endfunction

  // present one macropixel, with random idle cycles ahead of it
  task send_macropixel(input logic [7:0] y1, input logic [7:0] u,
                       input logic [7:0] y2, input logic [7:0] v, input logic fe);
    while (idle_on && ($urandom_range(99) < 31)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{luma_first: y1, chroma_blue: u, luma_second: y2,
                  chroma_red: v, frame_end_in: fe};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    idle_on      = 1'b1;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: luma and chroma extremes, neutral chroma, clipping both ways
    send_macropixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    send_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_macropixel(8'h00, 8'h80, 8'hFF, 8'h80, 1'b0);
    send_macropixel(8'h80, 8'h80, 8'h80, 8'h80, 1'b0);
    send_macropixel(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0);
    send_macropixel(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b1);
    send_macropixel(8'h80, 8'h00, 8'h80, 8'h00, 1'b0);
    send_macropixel(8'h80, 8'hFF, 8'h80, 8'hFF, 1'b0);
    send_macropixel(8'h10, 8'h80, 8'hEB, 8'h80, 1'b0);
    send_macropixel(8'h00, 8'h00, 8'hFF, 8'hFF, 1'b0);
    send_macropixel(8'hFF, 8'hFF, 8'h00, 8'h00, 1'b0);
    // small negative and positive chroma, floor rounding of the shift
    send_macropixel(8'h64, 8'h7F, 8'hC8, 8'h81, 1'b1);
    send_macropixel(8'h32, 8'h81, 8'h3C, 8'h7F, 1'b0);
    send_macropixel(8'h01, 8'h01, 8'hFE, 8'hFE, 1'b0);
    send_macropixel(8'hFE, 8'hFE, 8'h01, 8'h01, 1'b1);
    send_macropixel(8'hAA, 8'h55, 8'h55, 8'hAA, 1'b0);
    send_macropixel(8'h55, 8'hAA, 8'hAA, 8'h55, 1'b1);

    // random macropixels, middle stretch with no idling on either side
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      idle_on = !(i >= 550 && i < 1050);
      send_macropixel(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                      $urandom_range(15) == 0);
    end
    in_valid <= 1'b0;
    idle_on = 1'b1;

    // drain until every expected pair has been checked, then watch for stray result beats
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
